>>> rtl/s2umap_pkg.sv
// ----------------------------------------------------------------------------
// s2umap_pkg
// Shared types and constants for the sequence-to-UID map: beat payloads,
// request and status codes, the decoded command passed from front to back.
// ----------------------------------------------------------------------------
package s2umap_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths of the beats
  localparam int REQ_W  = 3;
  localparam int SEQ_W  = 11;
  localparam int UID_W  = 32;
  localparam int NUID_W = UID_W + 1;
  localparam int CMP_W  = ((CNT_W > SEQ_W) ? CNT_W : SEQ_W) + 1;

  // Command queue between front and back (depth is a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Request codes as they arrive on the input beat
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EXPUNGE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEQ2UID  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UID2SEQ  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_SEQ_RANGE = 3'd2,
    ST_UID_ORDER = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_EXPUNGE,
    OP_SEQ2UID,
    OP_UID2SEQ,
    OP_RESET
  } op_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SEQ_W-1:0] seq;
    logic [UID_W-1:0] uid;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [SEQ_W-1:0]  seq_out;
    logic [UID_W-1:0]  uid_out;
    logic [SEQ_W-1:0]  entry_count;
    logic [NUID_W-1:0] next_uid;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] seq;
    logic [UID_W-1:0] uid;
  } cmd_t;

endpackage

>>> rtl/sequence_to_uid_map.sv
// ----------------------------------------------------------------------------
// sequence_to_uid_map
// Ascending table of message UIDs addressed by 1-based sequence number,
// with append, expunge, lookup by sequence, binary search by UID and clear.
// ----------------------------------------------------------------------------
//
//   beat    direction  handshake               payload
//   ------  ---------  ----------------------  ----------------------
//   in      in         in_valid_i/in_stall_o   in_item_i  (in_item_t)
//   out     out        out_valid_o/out_stall_i out_item_o (out_item_t)
//
// One result beat per request beat, in order. A request sits in a two-deep
// command queue, then passes through the back end: append, clear and
// rejected requests go straight to the result, lookup by sequence makes one
// table read, UID search makes one table read and compare per probe, and
// expunge reads and rewrites each entry above the removed one; every step
// that touches a stored entry waits on the registered table read.
// Reset clears the count to zero and next-UID to one; table contents are left
// as they are and no clearing pass runs. A stalled result holds in the output
// register while the queue keeps taking request beats until it is full.
module sequence_to_uid_map (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  s2umap_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output s2umap_pkg::out_item_t out_item_o
);
  import s2umap_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  s2umap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  s2umap_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/s2umap_ram.sv
// ----------------------------------------------------------------------------
// s2umap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module s2umap_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/s2umap_front.sv
// ----------------------------------------------------------------------------
// s2umap_front
// Accepts request beats, decodes the request type and holds decoded
// commands in a short queue until the back end pops them.
// ----------------------------------------------------------------------------
module s2umap_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  s2umap_pkg::in_item_t  in_item_i,
  output logic                  cmd_valid_o,
  output s2umap_pkg::cmd_t      cmd_o,
  input  logic                  cmd_pop_i
);
  import s2umap_pkg::*;

  cmd_t               queue_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] fill_q, fill_d;
  logic               push;
  logic               pop;
  cmd_t               cmd_dec;

  // Classify the request
  always_comb begin
    cmd_dec.seq = in_item_i.seq;
    cmd_dec.uid = in_item_i.uid;
    case (in_item_i.req_type)
      REQ_APPEND:  cmd_dec.op = OP_APPEND;
      REQ_EXPUNGE: cmd_dec.op = OP_EXPUNGE;
      REQ_SEQ2UID: cmd_dec.op = OP_SEQ2UID;
      REQ_UID2SEQ: cmd_dec.op = OP_UID2SEQ;
      REQ_RESET:   cmd_dec.op = OP_RESET;
      default:     cmd_dec.op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (fill_q == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + Q_CNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the decoded beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_dec;
    end
  end

endmodule

>>> rtl/s2umap_back.sv
// ----------------------------------------------------------------------------
// s2umap_back
// Executes decoded commands against the UID table: append, expunge with
// entry shift, indexed read, binary search and clear. Holds the count,
// next-UID and the registered result beat.
// ----------------------------------------------------------------------------
module s2umap_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  s2umap_pkg::cmd_t      cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output s2umap_pkg::out_item_t out_item_o
);
  import s2umap_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_SRCH   = 6'b000100,
    S_SHRD   = 6'b001000,
    S_SHWR   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [NUID_W-1:0] expect_q, expect_d;
  status_e           status_q, status_d;
  logic [SEQ_W-1:0]  seq_out_q, seq_out_d;
  logic [UID_W-1:0]  uid_out_q, uid_out_d;
  logic [UID_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  mid_q, mid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [UID_W-1:0]  wdata;
  logic [IDX_W-1:0]  raddr;
  logic [UID_W-1:0]  rdata;

  logic              out_take;
  logic              seq_ok;
  logic [SEQ_W-1:0]  seq_m1;
  logic [CMP_W-1:0]  app_seq;
  logic [CNT_W:0]    half_cnt;
  logic [CNT_W-1:0]  mid_p1;
  logic [CNT_W-1:0]  lo_n;
  logic [CNT_W-1:0]  hi_n;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  shift_nxt;

  s2umap_ram #(
    .Width (UID_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Request checks and search bounds
  assign out_take  = out_valid_q && !out_stall_i;
  assign seq_ok    = (cmd_i.seq != '0) && (CMP_W'(cmd_i.seq) <= CMP_W'(count_q));
  assign seq_m1    = cmd_i.seq - SEQ_W'(1);
  assign app_seq   = CMP_W'(count_q) + CMP_W'(1);
  assign half_cnt  = {1'b0, count_q};
  assign mid_p1    = CNT_W'(mid_q) + CNT_W'(1);
  assign lo_n      = (rdata < key_q) ? mid_p1 : lo_q;
  assign hi_n      = (rdata < key_q) ? hi_q : CNT_W'(mid_q);
  assign mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
  assign shift_nxt = CNT_W'(idx_q) + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    expect_d    = expect_q;
    status_d    = status_q;
    seq_out_d   = seq_out_q;
    uid_out_d   = uid_out_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_take;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    raddr       = mid_q;
    cmd_pop_o   = 1'b0;

    case (state_q)
      // Pop a command and do its first step
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          status_d  = ST_OK;
          seq_out_d = '0;
          uid_out_d = '0;
          state_d   = S_DONE;
          case (cmd_i.op)
            OP_APPEND: begin
              if (CMP_W'(cmd_i.seq) != app_seq) begin
                status_d = ST_SEQ_RANGE;
              end else if ({1'b0, cmd_i.uid} < expect_q) begin
                status_d = ST_UID_ORDER;
              end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = count_q[IDX_W-1:0];
                wdata    = cmd_i.uid;
                count_d  = count_q + CNT_W'(1);
                expect_d = {1'b0, cmd_i.uid} + NUID_W'(1);
              end
            end
            OP_EXPUNGE: begin
              if (!seq_ok) begin
                status_d = ST_SEQ_RANGE;
              end else begin
                idx_d   = seq_m1[IDX_W-1:0];
                state_d = S_SHRD;
              end
            end
            OP_SEQ2UID: begin
              if (!seq_ok) begin
                status_d = ST_SEQ_RANGE;
              end else begin
                raddr   = seq_m1[IDX_W-1:0];
                state_d = S_RDWAIT;
              end
            end
            OP_UID2SEQ: begin
              key_d = cmd_i.uid;
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                lo_d    = '0;
                hi_d    = count_q;
                mid_d   = half_cnt[IDX_W:1];
                raddr   = half_cnt[IDX_W:1];
                state_d = S_SRCH;
              end
            end
            OP_RESET: begin
              count_d  = '0;
              expect_d = NUID_W'(1);
            end
            default: begin
            end
          endcase
        end
      end

      // Capture the indexed entry
      S_RDWAIT: begin
        uid_out_d = rdata;
        state_d   = S_DONE;
      end

      // Compare the probed entry; finish on a match or an empty window, else narrow the window and probe again
      S_SRCH: begin
        if (rdata == key_q) begin
          seq_out_d = SEQ_W'(mid_q) + SEQ_W'(1);
          state_d   = S_DONE;
        end else if (lo_n < hi_n) begin
          lo_d  = lo_n;
          hi_d  = hi_n;
          mid_d = mid_sum[IDX_W:1];
          raddr = mid_sum[IDX_W:1];
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end

      // Read the entry above the hole, or finish the shift
      S_SHRD: begin
        if (shift_nxt < count_q) begin
          raddr   = shift_nxt[IDX_W-1:0];
          state_d = S_SHWR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      // Move that entry down one place
      S_SHWR: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = rdata;
        idx_d   = idx_q + IDX_W'(1);
        state_d = S_SHRD;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_take) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.seq_out     = seq_out_q;
          out_d.uid_out     = uid_out_q;
          out_d.entry_count = SEQ_W'(count_q);
          out_d.next_uid    = expect_q;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      expect_q    <= NUID_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      expect_q    <= expect_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    seq_out_q <= seq_out_d;
    uid_out_q <= uid_out_d;
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    idx_q     <= idx_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/s2umap_checker.sv
// ----------------------------------------------------------------------------
// s2umap_checker
// Port-level checks on the sequence-to-UID map, bound to the top level.
// ----------------------------------------------------------------------------
module s2umap_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input s2umap_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input s2umap_pkg::out_item_t out_item_o
);
  import s2umap_pkg::*;

  logic [3:0] pend_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Track requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !out_beat) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_beat && !in_beat) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result beat changed");

  // Answer only requests that were taken
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result beat without a pending request");

  // Drop lookup data on any failed request
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.uid_out == '0 && out_item_o.seq_out == '0)
    else $error("failed request carries lookup data");

  // Keep the count within the table
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.entry_count) <= 32'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind sequence_to_uid_map s2umap_checker u_s2umap_checker (.*);
